// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/cmdp_pkg.sv =====
package cmdp_pkg;

   localparam int RESULT_BITS = 32;

   localparam logic [7:0] SEPARATOR    = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CASE_BIT     = 8'h20;
   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   localparam logic [1:0] COUNT_MAX = 2'd3;
   localparam logic [1:0] COUNT_TWO = 2'd2;
   localparam logic [1:0] COUNT_ONE = 2'd1;

   typedef enum logic [1:0] {
      PHASE_BETWEEN,
      PHASE_LEAD_ZERO,
      PHASE_IN_WORD
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_line;
   } item_type;

   typedef struct packed {
      logic                   parse_ok;
      logic [RESULT_BITS-1:0] first_number;
      logic [RESULT_BITS-1:0] second_number;
   } result_type;

endpackage

// ===== sv/cmdp_in_stage.sv =====
module cmdp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cmdp_pkg::item_type req_item,
   input  logic               advance,
   output logic               stg_valid,
   output cmdp_pkg::item_type stg_item
);

   logic               valid_ff;
   logic               valid_in;
   cmdp_pkg::item_type item_ff;
   logic               take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);
   assign stg_valid = valid_ff;
   assign stg_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== sv/cmdp_parser.sv =====
`include "assert_macros.svh"

module cmdp_parser #(
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  cmdp_pkg::item_type   item,
   output logic                 load,
   output cmdp_pkg::result_type result
);

   localparam int WIDE_BITS = (VALUE_BITS > cmdp_pkg::RESULT_BITS) ? VALUE_BITS
                                                                 : cmdp_pkg::RESULT_BITS;

   cmdp_pkg::phase_type   phase_ff, phase_in;
   logic [1:0]            count_ff, count_in;
   logic                  hex_ff, hex_in;
   logic                  wvalid_ff, wvalid_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] first_ff, first_in;
   logic                  fvalid_ff, fvalid_in;

   logic [7:0]            c;
   logic [7:0]            lower;
   logic                  is_dec;
   logic                  is_hex_letter;
   logic                  is_x;
   logic [3:0]            dec_digit;
   logic [3:0]            hex_digit;
   logic [VALUE_BITS-1:0] acc_base;
   logic [VALUE_BITS-1:0] dec_acc;
   logic [VALUE_BITS-1:0] hex_acc;
   logic [WIDE_BITS-1:0]  first_wide;
   logic [WIDE_BITS-1:0]  second_wide;
   logic                  ok;

   assign c             = item.char_code;
   assign lower         = (c >= cmdp_pkg::CHAR_UPPER_A && c <= cmdp_pkg::CHAR_UPPER_Z)
                          ? (c | cmdp_pkg::CASE_BIT) : c;
   assign is_dec        = (c >= cmdp_pkg::CHAR_ZERO) && (c <= cmdp_pkg::CHAR_NINE);
   assign is_hex_letter = (lower >= cmdp_pkg::CHAR_LOWER_A)
                          && (lower <= cmdp_pkg::CHAR_LOWER_F);
   assign is_x          = (lower == cmdp_pkg::CHAR_LOWER_X);
   assign dec_digit     = c[3:0];
   assign hex_digit     = is_dec ? c[3:0] : 4'(lower[3:0] + cmdp_pkg::HEX_LETTER_OFFSET);

   assign acc_base = (phase_ff == cmdp_pkg::PHASE_BETWEEN) ? '0 : acc_ff;
   assign dec_acc  = (acc_base << 3) + (acc_base << 1) + VALUE_BITS'(dec_digit);
   assign hex_acc  = (acc_base << 4) + VALUE_BITS'(hex_digit);

   assign ok          = (count_ff == cmdp_pkg::COUNT_TWO) && fvalid_ff && wvalid_ff;
   assign first_wide  = WIDE_BITS'(first_ff);
   assign second_wide = WIDE_BITS'(acc_ff);

   assign load                 = step && item.end_of_line;
   assign result.parse_ok      = ok;
   assign result.first_number  = ok ? first_wide[cmdp_pkg::RESULT_BITS-1:0] : '0;
   assign result.second_number = ok ? second_wide[cmdp_pkg::RESULT_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cmdp_pkg::PHASE_BETWEEN;
         count_ff  <= '0;
         hex_ff    <= 1'b0;
         wvalid_ff <= 1'b1;
         acc_ff    <= '0;
         first_ff  <= '0;
         fvalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         hex_ff    <= hex_in;
         wvalid_ff <= wvalid_in;
         acc_ff    <= acc_in;
         first_ff  <= first_in;
         fvalid_ff <= fvalid_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      hex_in    = hex_ff;
      wvalid_in = wvalid_ff;
      acc_in    = acc_ff;
      first_in  = first_ff;
      fvalid_in = fvalid_ff;
      if (step) begin
         if (item.end_of_line) begin
            phase_in  = cmdp_pkg::PHASE_BETWEEN;
            count_in  = '0;
            hex_in    = 1'b0;
            wvalid_in = 1'b1;
            acc_in    = '0;
            first_in  = '0;
            fvalid_in = 1'b0;
         end else if (c == cmdp_pkg::SEPARATOR) begin
            if (phase_ff != cmdp_pkg::PHASE_BETWEEN && count_ff == cmdp_pkg::COUNT_ONE) begin
               first_in  = acc_ff;
               fvalid_in = wvalid_ff;
            end
            phase_in = cmdp_pkg::PHASE_BETWEEN;
         end else begin
            unique case (phase_ff)
               cmdp_pkg::PHASE_BETWEEN: begin
                  if (count_ff != cmdp_pkg::COUNT_MAX) begin
                     count_in = 2'(count_ff + 2'd1);
                  end
                  hex_in = 1'b0;
                  if (c == cmdp_pkg::CHAR_ZERO) begin
                     phase_in  = cmdp_pkg::PHASE_LEAD_ZERO;
                     wvalid_in = 1'b1;
                     acc_in    = '0;
                  end else begin
                     phase_in  = cmdp_pkg::PHASE_IN_WORD;
                     wvalid_in = is_dec;
                     acc_in    = is_dec ? dec_acc : '0;
                  end
               end
               cmdp_pkg::PHASE_LEAD_ZERO: begin
                  phase_in = cmdp_pkg::PHASE_IN_WORD;
                  if (is_x) begin
                     hex_in = 1'b1;
                     acc_in = '0;
                  end else if (is_dec) begin
                     acc_in = dec_acc;
                  end else begin
                     wvalid_in = 1'b0;
                  end
               end
               cmdp_pkg::PHASE_IN_WORD: begin
                  if (hex_ff) begin
                     if (is_dec || is_hex_letter) begin
                        acc_in = hex_acc;
                     end else begin
                        wvalid_in = 1'b0;
                     end
                  end else if (is_dec) begin
                     acc_in = dec_acc;
                  end else begin
                     wvalid_in = 1'b0;
                  end
               end
               default: begin
                  phase_in = cmdp_pkg::PHASE_BETWEEN;
               end
            endcase
         end
      end
   end

   `ASSERT_NEXT(a_eol_restarts, clock, reset, load, count_ff == '0 && !fvalid_ff)
   `ASSERT_IMPLIES(a_zero_not_hex, clock, reset, phase_ff == cmdp_pkg::PHASE_LEAD_ZERO, !hex_ff)
   `ASSERT_IMPLIES(a_word_counted, clock, reset, phase_ff != cmdp_pkg::PHASE_BETWEEN, count_ff != '0)

endmodule

// ===== sv/cmdp_rsp_stage.sv =====
`include "assert_macros.svh"

module cmdp_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cmdp_pkg::result_type result,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cmdp_pkg::result_type rsp_result
);

   logic                 valid_ff;
   cmdp_pkg::result_type result_ff;

   assign free       = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, load, !valid_ff || rsp_ready)

endmodule

// ===== sv/two_number_command_line_parser_unit.sv =====
// A request is registered in the input stage, then processed; the result of an
// end-of-line request is registered in the response stage and held until taken.
// Throughput: one request per cycle; the result register frees as it is taken,
// so only an end-of-line request waits, and only while the previous result is held.
// Reset (synchronous, active high) empties both registers and clears the parser.
module two_number_command_line_parser_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_parse_ok,
   output logic [31:0] rsp_first_number,
   output logic [31:0] rsp_second_number
);

   cmdp_pkg::item_type   req_item;
   cmdp_pkg::item_type   stg_item;
   cmdp_pkg::result_type result;
   cmdp_pkg::result_type rsp_result;
   logic                 stg_valid;
   logic                 advance;
   logic                 load;
   logic                 free;

   assign req_item.char_code   = req_char_code;
   assign req_item.end_of_line = req_end_of_line;
   assign advance = stg_valid && (!stg_item.end_of_line || free);

   cmdp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (advance),
      .stg_valid (stg_valid),
      .stg_item  (stg_item)
   );

   cmdp_parser #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (stg_item),
      .load   (load),
      .result (result)
   );

   cmdp_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .free       (free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_parse_ok      = rsp_result.parse_ok;
   assign rsp_first_number  = rsp_result.first_number;
   assign rsp_second_number = rsp_result.second_number;

endmodule
